// ----- rtl/tle_pkg.sv -----
package tle_pkg;

    // Default line width in characters.
    localparam int LINE_WIDTH_DEF = 40;

    localparam int ACTION_W = 3;
    localparam int ERASE_W  = 6;

    // Echo actions.
    localparam logic [ACTION_W-1:0] ACT_ECHO    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_ERASE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_NEWLINE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_BELL    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_END     = 3'd4;

    // Keyboard codes.
    localparam logic [7:0] KEY_EOF        = 8'd4;
    localparam logic [7:0] KEY_BS         = 8'd8;
    localparam logic [7:0] KEY_KILL       = 8'd21;
    localparam logic [7:0] KEY_WERASE     = 8'd23;
    localparam logic [7:0] KEY_SPACE      = 8'd32;
    localparam logic [7:0] KEY_LAST_PRINT = 8'd126;
    localparam logic [7:0] KEY_DEL        = 8'd127;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [7:0]          echo_value;
        logic [ERASE_W-1:0]  erase_count;
        logic                last_of_run;
    } result_t;

    typedef struct packed {
        logic    push;
        result_t res;
    } res_push_t;

endpackage

// ----- rtl/tle_line_mem.sv -----
module tle_line_mem #(
    parameter int LINE_WIDTH = tle_pkg::LINE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(LINE_WIDTH)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(LINE_WIDTH)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [LINE_WIDTH];
    logic [7:0] rd_data_reg;

    // One write port and one registered read port; the read data holds
    // until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tle_out_stage.sv -----
module tle_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  tle_pkg::res_push_t  push_in,
    output logic                room,
    output logic                res_valid,
    input  logic                res_stall,
    output tle_pkg::result_t    res
);

    import tle_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new word may be loaded when the register is empty or is being taken.
    assign room       = !valid_reg || !res_stall;
    assign valid_next = push_in.push || (valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_in.push)
        begin
            res_reg <= push_in.res;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/tle_ctrl.sv -----
module tle_ctrl #(
    parameter int LINE_WIDTH = tle_pkg::LINE_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          key_valid,
    output logic                          key_stall,
    input  logic [7:0]                    key_byte,
    input  logic                          room,
    output tle_pkg::res_push_t            push_out,
    output logic                          mem_wr_en,
    output logic [$clog2(LINE_WIDTH)-1:0] mem_wr_addr,
    output logic [7:0]                    mem_wr_data,
    output logic                          mem_rd_en,
    output logic [$clog2(LINE_WIDTH)-1:0] mem_rd_addr,
    input  logic [7:0]                    mem_rd_data
);

    import tle_pkg::*;

    localparam int ADDR_W = $clog2(LINE_WIDTH);
    localparam int LEN_W  = $clog2(LINE_WIDTH + 1);
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LINE_WIDTH);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_ERASE   = 4'd3;
    localparam logic [3:0] S_NL      = 4'd4;
    localparam logic [3:0] S_COPY_RD = 4'd5;
    localparam logic [3:0] S_COPY    = 4'd6;
    localparam logic [3:0] S_STORE   = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             closed_reg, closed_next;
    logic [7:0]       key_reg, key_next;
    logic [LEN_W-1:0] scan_n_reg, scan_n_next;
    logic             phase_reg, phase_next;
    logic             wrap_reg, wrap_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] start_reg, start_next;
    logic [LEN_W-1:0] j_reg, j_next;

    logic             is_space;
    logic             scan_dec;
    logic             is_print;
    logic [LEN_W-1:0] n_dec;
    logic [LEN_W-1:0] n_dec_m1;
    logic [LEN_W-1:0] len_m1;
    logic [LEN_W-1:0] found;
    logic [LEN_W-1:0] j_inc;
    logic [LEN_W-1:0] src_first;
    logic [LEN_W-1:0] src_next;

    assign is_space  = (mem_rd_data == KEY_SPACE);
    assign scan_dec  = !phase_reg || !is_space;
    assign is_print  = (key_reg >= KEY_SPACE) && (key_reg <= KEY_LAST_PRINT);
    assign n_dec     = scan_n_reg - LEN_ONE;
    assign n_dec_m1  = n_dec - LEN_ONE;
    assign len_m1    = len_reg - LEN_ONE;
    assign found     = scan_dec ? '0 : scan_n_reg;
    assign j_inc     = j_reg + LEN_ONE;
    assign src_first = start_reg;
    assign src_next  = start_reg + j_inc;

    assign key_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        closed_next = closed_reg;
        key_next    = key_reg;
        scan_n_next = scan_n_reg;
        phase_next  = phase_reg;
        wrap_next   = wrap_reg;
        cnt_next    = cnt_reg;
        start_next  = start_reg;
        j_next      = j_reg;
        push_out    = '0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (key_valid && !closed_reg)
                begin
                    key_next   = key_byte;
                    state_next = S_DISP;
                end
            end

            S_DISP:
            begin
                if (key_reg == KEY_EOF && len_reg == '0)
                begin
                    if (room)
                    begin
                        push_out.push            = 1'b1;
                        push_out.res.action      = ACT_END;
                        push_out.res.last_of_run = 1'b1;
                        closed_next              = 1'b1;
                        state_next               = S_IDLE;
                    end
                end
                else if (key_reg == KEY_BS || key_reg == KEY_DEL)
                begin
                    if (len_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (room)
                    begin
                        push_out.push            = 1'b1;
                        push_out.res.action      = ACT_ERASE;
                        push_out.res.erase_count = ERASE_W'(1);
                        push_out.res.last_of_run = 1'b1;
                        len_next                 = len_m1;
                        state_next               = S_IDLE;
                    end
                end
                else if (key_reg == KEY_KILL)
                begin
                    if (len_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (room)
                    begin
                        push_out.push            = 1'b1;
                        push_out.res.action      = ACT_ERASE;
                        push_out.res.erase_count = ERASE_W'(len_reg);
                        push_out.res.last_of_run = 1'b1;
                        len_next                 = '0;
                        state_next               = S_IDLE;
                    end
                end
                else if (key_reg == KEY_WERASE)
                begin
                    if (len_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = len_m1[ADDR_W-1:0];
                        scan_n_next = len_reg;
                        phase_next  = 1'b0;
                        wrap_next   = 1'b0;
                        state_next  = S_SCAN;
                    end
                end
                else if (is_print)
                begin
                    if (len_reg < FULL_LEN)
                    begin
                        wrap_next  = 1'b0;
                        state_next = S_STORE;
                    end
                    else
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = len_m1[ADDR_W-1:0];
                        scan_n_next = len_reg;
                        phase_next  = 1'b1;
                        wrap_next   = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
                else if (room)
                begin
                    push_out.push            = 1'b1;
                    push_out.res.action      = ACT_BELL;
                    push_out.res.last_of_run = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (scan_dec && n_dec != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = n_dec_m1[ADDR_W-1:0];
                    scan_n_next = n_dec;
                    if (!is_space)
                    begin
                        phase_next = 1'b1;
                    end
                end
                else
                begin
                    cnt_next   = len_reg - found;
                    start_next = found;
                    if (!wrap_reg)
                    begin
                        len_next   = found;
                        state_next = S_ERASE;
                    end
                    else if (found == '0)
                    begin
                        len_next   = '0;
                        state_next = S_NL;
                    end
                    else
                    begin
                        len_next   = len_reg - found;
                        state_next = (len_reg != found) ? S_ERASE : S_NL;
                    end
                end
            end

            S_ERASE:
            begin
                if (room)
                begin
                    push_out.push            = 1'b1;
                    push_out.res.action      = ACT_ERASE;
                    push_out.res.erase_count = ERASE_W'(cnt_reg);
                    push_out.res.last_of_run = !wrap_reg;
                    state_next               = wrap_reg ? S_NL : S_IDLE;
                end
            end

            S_NL:
            begin
                if (room)
                begin
                    push_out.push       = 1'b1;
                    push_out.res.action = ACT_NEWLINE;
                    j_next              = '0;
                    state_next          = (len_reg != '0) ? S_COPY_RD : S_STORE;
                end
            end

            S_COPY_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = src_first[ADDR_W-1:0];
                state_next  = S_COPY;
            end

            S_COPY:
            begin
                if (room)
                begin
                    push_out.push           = 1'b1;
                    push_out.res.action     = ACT_ECHO;
                    push_out.res.echo_value = mem_rd_data;
                    mem_wr_en               = 1'b1;
                    mem_wr_addr             = j_reg[ADDR_W-1:0];
                    mem_wr_data             = mem_rd_data;
                    if (j_inc < len_reg)
                    begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = src_next[ADDR_W-1:0];
                        j_next      = j_inc;
                    end
                    else
                    begin
                        state_next = S_STORE;
                    end
                end
            end

            S_STORE:
            begin
                if (room)
                begin
                    push_out.push            = 1'b1;
                    push_out.res.action      = ACT_ECHO;
                    push_out.res.echo_value  = key_reg;
                    push_out.res.last_of_run = 1'b1;
                    mem_wr_en                = 1'b1;
                    mem_wr_addr              = len_reg[ADDR_W-1:0];
                    mem_wr_data              = key_reg;
                    len_next                 = len_reg + LEN_ONE;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            closed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            closed_reg <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        scan_n_reg <= scan_n_next;
        phase_reg  <= phase_next;
        wrap_reg   <= wrap_next;
        cnt_reg    <= cnt_next;
        start_reg  <= start_next;
        j_reg      <= j_next;
    end

endmodule

// ----- rtl/terminal_line_editor_word_wrap.sv -----
// Terminal line editor with word wrap.
// The key channel (key_valid, key_stall, key_byte) takes one keyboard byte
// per word. The result channel (res_valid, res_stall and the four result
// fields) gives the echo actions for that byte, one word each, the last of
// a run marked by last_of_run. A byte may cause no result at all.
// The line is held in a memory of LINE_WIDTH characters with a registered read.
// Without stalls, a printable byte that finds room passes through the dispatch
// and store states before the next byte is accepted, and its result is loaded
// in the store state; a single erase, a line kill, a bell or the end of input
// is handled in the dispatch state alone, which loads its result. A word erase
// walks back through the memory one character per cycle. A wrap scans back for
// the last space and then copies the trailing word to the start of the line,
// one character per cycle while the output register has room. The memory's
// single read port sets this pace.
// Reset empties the line and reopens input; the memory itself is not
// cleared, as only characters below the line length are ever read.
// When the receiver stalls, the result waits in the output register and
// the editor pauses before producing the next one; a new byte is still
// taken while the last result of the previous byte waits.
module terminal_line_editor_word_wrap #(
    parameter int LINE_WIDTH = tle_pkg::LINE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           key_valid,
    output logic                           key_stall,
    input  logic [7:0]                     key_byte,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [tle_pkg::ACTION_W-1:0]   action,
    output logic [7:0]                     echo_value,
    output logic [tle_pkg::ERASE_W-1:0]    erase_count,
    output logic                           last_of_run
);

    import tle_pkg::*;

    localparam int ADDR_W = $clog2(LINE_WIDTH);

    // Controller to output register, and output register back-pressure.
    res_push_t   push;
    logic        room;
    result_t     res;

    // Line memory port signals.
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;

    // The controller sequences each byte, using the line memory where needed, and
    // hands each result word to the output register when it has room.
    tle_ctrl #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .key_byte    (key_byte),
        .room        (room),
        .push_out    (push),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // The stored characters of the current line.
    tle_line_mem #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // The output register separates the editor from a stalling receiver.
    tle_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_in   (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign action      = res.action;
    assign echo_value  = res.echo_value;
    assign erase_count = res.erase_count;
    assign last_of_run = res.last_of_run;

endmodule

// ----- verif/terminal_line_editor_word_wrap_tb.sv -----
module terminal_line_editor_word_wrap_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tle_pkg::*;

    localparam int LINE_WIDTH = LINE_WIDTH_DEF;

    // Longest idle stretch that either side draws for one word.
    localparam int MAX_GAP = 18;

    // The long hold-off of the result side, used to fill the editor up.
    localparam int LONG_HOLD = 500;

    // Cycles with no word accepted on either channel before the run is abandoned.
    // The limit lies well above both the slowest correct item (a wrap at full
    // width, every result stalled to the maximum) and the long hold-off.
    localparam int IDLE_LIMIT = 4000;

    // Quiet cycles after the last expected result: a wrap scans and copies the
    // whole line, so anything stray would show up well within this.
    localparam int SETTLE_CYCLES = 2 * LINE_WIDTH + 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                key_valid = 1'b0;
    logic                key_stall;
    logic [7:0]          key_byte = 8'h00;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [ACTION_W-1:0] action;
    logic [7:0]          echo_value;
    logic [ERASE_W-1:0]  erase_count;
    logic                last_of_run;

    // Our own copy of the editor's line, kept in step with every key word
    // the editor accepts.
    logic [7:0] line_chars [LINE_WIDTH];
    int         line_len;
    bit         input_ended;

    // Echo actions still owed by the editor, oldest first.
    result_t    echo_expected [$];

    int         error_count;

    // Idling bounds for each side; the tests change them to mix busy and
    // quiet stretches. A non-zero hold request makes the result side stall
    // for that many cycles once.
    int         key_gap_max;
    int         res_gap_max;
    int         hold_request;

    terminal_line_editor_word_wrap dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_valid   (key_valid),
        .key_stall   (key_stall),
        .key_byte    (key_byte),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .action      (action),
        .echo_value  (echo_value),
        .erase_count (erase_count),
        .last_of_run (last_of_run)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic result_t make_result(input logic [ACTION_W-1:0] act,
                                            input logic [7:0] ch,
                                            input int cnt);
        result_t r;
        r.action      = act;
        r.echo_value  = ch;
        r.erase_count = ERASE_W'(cnt);
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Works out the echo actions for one accepted key and updates our line.
    function automatic void predict_echo(input logic [7:0] key);
        result_t run [$];
        result_t tail;
        int      n;
        int      start;
        int      wlen;
        if (input_ended)
            return;
        if (key == KEY_EOF && line_len == 0)
        begin
            input_ended = 1'b1;
            run.push_back(make_result(ACT_END, 8'h00, 0));
        end
        else if (key == KEY_BS || key == KEY_DEL)
        begin
            if (line_len > 0)
            begin
                line_len--;
                run.push_back(make_result(ACT_ERASE, 8'h00, 1));
            end
        end
        else if (key == KEY_KILL)
        begin
            if (line_len > 0)
            begin
                run.push_back(make_result(ACT_ERASE, 8'h00, line_len));
                line_len = 0;
            end
        end
        else if (key == KEY_WERASE)
        begin
            // Trailing spaces go first, then the word before them, all as one
            // erase.
            n = line_len;
            while (n > 0 && line_chars[n-1] == KEY_SPACE)
                n--;
            while (n > 0 && line_chars[n-1] != KEY_SPACE)
                n--;
            if (n < line_len)
            begin
                run.push_back(make_result(ACT_ERASE, 8'h00, line_len - n));
                line_len = n;
            end
        end
        else if (key >= KEY_SPACE && key <= KEY_LAST_PRINT)
        begin
            if (line_len >= LINE_WIDTH)
            begin
                start = line_len;
                while (start > 0 && line_chars[start-1] != KEY_SPACE)
                    start--;
                if (start == 0)
                begin
                    // One unbroken run of glyphs: the line is simply dropped.
                    run.push_back(make_result(ACT_NEWLINE, 8'h00, 0));
                    line_len = 0;
                end
                else
                begin
                    // Take the trailing word off the screen and carry it to
                    // the start of the next line.
                    wlen = line_len - start;
                    if (wlen > 0)
                        run.push_back(make_result(ACT_ERASE, 8'h00, wlen));
                    run.push_back(make_result(ACT_NEWLINE, 8'h00, 0));
                    for (n = 0; n < wlen; n++)
                    begin
                        line_chars[n] = line_chars[start+n];
                        run.push_back(make_result(ACT_ECHO, line_chars[n], 0));
                    end
                    line_len = wlen;
                end
            end
            if (line_len < LINE_WIDTH)
            begin
                line_chars[line_len] = key;
                line_len++;
            end
            run.push_back(make_result(ACT_ECHO, key, 0));
        end
        else
        begin
            run.push_back(make_result(ACT_BELL, 8'h00, 0));
        end
        if (run.size() > 0)
        begin
            tail = run.pop_back();
            tail.last_of_run = 1'b1;
            run.push_back(tail);
        end
        foreach (run[i])
            echo_expected.push_back(run[i]);
    endfunction

    // Compares the result word on the outputs with the oldest expectation.
    function automatic void compare_echo();
        result_t want;
        if (echo_expected.size() == 0)
        begin
            $error("unexpected result: action %0d echo_value %0d erase_count %0d last %0d",
                   action, echo_value, erase_count, last_of_run);
            error_count++;
            return;
        end
        want = echo_expected.pop_front();
        if (action !== want.action)
        begin
            $error("action: expected %0d, got %0d", want.action, action);
            error_count++;
        end
        if (echo_value !== want.echo_value)
        begin
            $error("echo_value: expected %0d, got %0d", want.echo_value, echo_value);
            error_count++;
        end
        if (erase_count !== want.erase_count)
        begin
            $error("erase_count: expected %0d, got %0d", want.erase_count, erase_count);
            error_count++;
        end
        if (last_of_run !== want.last_of_run)
        begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, last_of_run);
            error_count++;
        end
    endfunction

    // A random printable character other than the space.
    function automatic logic [7:0] rand_glyph();
        return 8'($urandom_range(KEY_SPACE + 1, KEY_LAST_PRINT));
    endfunction

    // Draws a key for typing-like traffic. edit_pct is the share of editing
    // keys; the rest is mostly glyphs and spaces with a little raw noise.
    function automatic logic [7:0] pick_key(input int edit_pct);
        logic [7:0] k;
        int         r;
        r = $urandom_range(0, 99);
        if (r < edit_pct)
        begin
            case ($urandom_range(0, 5))
                0:       k = KEY_BS;
                1:       k = KEY_DEL;
                2:       k = KEY_WERASE;
                3:       k = KEY_WERASE;
                4:       k = KEY_KILL;
                default: k = KEY_EOF;
            endcase
        end
        else if (r < edit_pct + 8)
            k = 8'($urandom_range(0, 255));
        else if (r < edit_pct + 22)
            k = KEY_SPACE;
        else
            k = rand_glyph();
        // End of file on an empty line would close the input for good, which
        // only the last test is allowed to do.
        if (k == KEY_EOF && line_len == 0)
            k = rand_glyph();
        return k;
    endfunction

    // Offers one key word after a random gap and waits until it is taken.
    // Valid stays high across back-to-back words; it is only lowered when a
    // gap is actually drawn.
    task automatic send_key(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, key_gap_max);
        if (gap > 0)
        begin
            key_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        key_valid <= 1'b1;
        key_byte  <= b;
        @(posedge clk);
        while (key_stall)
            @(posedge clk);
        predict_echo(b);
    endtask

    // Withdraws the key word so that it is not taken twice, then waits for
    // every expected result.
    task automatic wait_drained();
        key_valid <= 1'b0;
        @(posedge clk);
        while (echo_expected.size() != 0)
            @(posedge clk);
    endtask

    // Erasing on an empty line, bell bytes at both ends of the byte range,
    // the printable extremes, end of file on a non-empty line, single-character
    // erases, and the line kill and word erase with multi-character counts.
    task automatic test_directed();
        logic [7:0] keys [$] = '{KEY_BS, KEY_DEL, KEY_KILL, KEY_WERASE,
                                 8'h00, 8'h1F, 8'h80, 8'hFF,
                                 KEY_SPACE, KEY_LAST_PRINT, "a", "b", KEY_SPACE, KEY_SPACE,
                                 KEY_EOF, KEY_WERASE, KEY_DEL,
                                 "x", "y", "z", KEY_KILL, KEY_WERASE, KEY_BS};
        key_gap_max = MAX_GAP;
        res_gap_max = MAX_GAP;
        foreach (keys[i])
            send_key(keys[i]);
    endtask

    // The three kinds of wrap at full width, the longest possible run of
    // results, and the widest possible erase.
    task automatic test_line_wrap();
        int i;
        key_gap_max = 0;
        res_gap_max = 0;
        // A full line without a single space simply breaks.
        for (i = 0; i < LINE_WIDTH; i++)
            send_key(rand_glyph());
        send_key(rand_glyph());
        // A full line ending in a space: newline, then the new character.
        while (line_len < LINE_WIDTH - 1)
            send_key(rand_glyph());
        send_key(KEY_SPACE);
        key_gap_max = MAX_GAP;
        res_gap_max = MAX_GAP;
        send_key(rand_glyph());
        // A leading space and glyphs up to full width give the longest word
        // that can still be carried over, and so the longest run of results.
        send_key(KEY_KILL);
        send_key(KEY_SPACE);
        while (line_len < LINE_WIDTH)
            send_key(rand_glyph());
        send_key(rand_glyph());
        // The line is now all glyphs, so a word erase clears the full width.
        send_key(KEY_WERASE);
        // Plain sentences that wrap a few times.
        for (i = 0; i < 2 * LINE_WIDTH; i++)
            send_key(($urandom_range(0, 4) == 0) ? KEY_SPACE : rand_glyph());
    endtask

    // Mostly well-formed typing with few edits, so that lines fill and wrap
    // often. Idling is switched on and off in stretches.
    task automatic test_random_typing(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
            begin
                key_gap_max = $urandom_range(0, 1) * MAX_GAP;
                res_gap_max = $urandom_range(0, 1) * MAX_GAP;
            end
            send_key(pick_key(4));
        end
    endtask

    // Heavy editing and raw noise over the whole byte range.
    task automatic test_random_bytes(input int count);
        int i;
        key_gap_max = MAX_GAP;
        res_gap_max = MAX_GAP;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 1) == 0)
                send_key(pick_key(30));
            else if (line_len == 0)
                send_key(rand_glyph());
            else
                send_key(8'($urandom_range(0, 255)));
        end
    endtask

    // The result side holds off for a long stretch while keys keep coming
    // without a gap, so the editor fills up and stalls its key channel.
    task automatic test_backpressure(input int count);
        int i;
        wait_drained();
        key_gap_max  = 0;
        res_gap_max  = 0;
        hold_request = LONG_HOLD;
        for (i = 0; i < count; i++)
            send_key(pick_key(8));
        res_gap_max = MAX_GAP;
    endtask

    // Short bursts, each followed by a pause until every result is in, so
    // that keys also arrive at a completely idle editor.
    task automatic test_drain_pause(input int count);
        int i;
        key_gap_max = 0;
        res_gap_max = MAX_GAP;
        for (i = 0; i < count; i++)
        begin
            send_key(pick_key(15));
            if (i % 4 == 3)
                wait_drained();
        end
    endtask

    // End of file on an empty line closes the input; everything after it is
    // taken but must give no result at all.
    task automatic test_end_of_input();
        int i;
        key_gap_max = MAX_GAP;
        res_gap_max = MAX_GAP;
        if (line_len > 0)
            send_key(KEY_KILL);
        send_key(KEY_EOF);
        send_key(KEY_EOF);
        send_key(rand_glyph());
        send_key(KEY_BS);
        for (i = 0; i < 8; i++)
            send_key(8'($urandom_range(0, 255)));
    endtask

    // Result side: draws a stall for every word, then takes the next one and
    // checks it. res_stall only ever gets one assignment per time step.
    initial
    begin : result_sink
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end
            else
                wait_cycles = $urandom_range(0, res_gap_max);
            if (wait_cycles > 0)
            begin
                res_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            compare_echo();
        end
    end

    // Ends the run if neither channel moves a word for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((key_valid && !key_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no word accepted for %0d cycles", IDLE_LIMIT);
        $display("terminal_line_editor_word_wrap_tb failed");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_line_wrap();
        test_random_typing(70);
        test_random_bytes(40);
        test_backpressure(30);
        test_drain_pause(16);
        test_end_of_input();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("terminal_line_editor_word_wrap_tb passed");
        else
            $display("terminal_line_editor_word_wrap_tb failed");
        $finish;
    end

endmodule
